>>> sv/irav_pkg.sv
// shared widths, constants and types of the infrared range averaging block
package irav_pkg;

  // ring geometry
  localparam int RING_DEPTH   = 8;
  localparam int SENSOR_COUNT = 3;

  // field widths
  localparam int CHANNEL_W  = 2;
  localparam int SAMPLE_W   = 10;
  localparam int AVERAGE_W  = 10;
  localparam int DISTANCE_W = 12;
  localparam int MODEL_W    = 1;
  localparam int SUM_W      = 16;

  // fixed-point power law
  localparam int X_W        = 31;   // log mantissa, q30 in [1,2)
  localparam int FRAC_W     = 16;   // q16 fraction of log2 and of the exponent product
  localparam int MSB_W      = 4;    // integer part of log2 of a 10 bit value
  localparam int L_W        = MSB_W + FRAC_W;
  localparam int EXP_W      = 17;
  localparam int COEF_W     = 18;
  localparam int R_W        = 31;   // 2^-f in q30
  localparam int RAD_W      = 2 * R_W;
  localparam int REM_W      = R_W + 2;
  localparam int ROOT_STEPS = R_W;

  localparam int MIN_SHORT      = 30;
  localparam int MIN_MEDIUM     = 50;
  localparam int COEF_SHORT     = 18684;
  localparam int COEF_MEDIUM    = 213184;
  localparam int EXP_SHORT_Q16  = 62390;
  localparam int EXP_MEDIUM_Q16 = 73728;

  typedef logic [CHANNEL_W-1:0]  channel_t;
  typedef logic [SAMPLE_W-1:0]   sample_t;
  typedef logic [AVERAGE_W-1:0]  average_t;
  typedef logic [DISTANCE_W-1:0] distance_t;

  typedef enum logic [MODEL_W-1:0] {
    MODEL_SHORT  = 1'b0,
    MODEL_MEDIUM = 1'b1
  } model_t;

endpackage

>>> sv/irav_in_if.sv
// sample channel: one sensor reading per word
interface irav_in_if;
  logic               valid;
  logic               ready;
  irav_pkg::channel_t channel;
  irav_pkg::sample_t  sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

>>> sv/irav_out_if.sv
// result channel: averaged reading and distance per word
interface irav_out_if;
  logic                valid;
  logic                ready;
  irav_pkg::channel_t  channel_out;
  irav_pkg::average_t  average;
  irav_pkg::distance_t distance_mm;

  modport source (output valid, output channel_out, output average, output distance_mm,
                  input ready);
  modport sink   (input valid, input channel_out, input average, input distance_mm,
                  output ready);
endinterface

>>> sv/irav_cfg_if.sv
// configuration write channel carrying the sensor model select
interface irav_cfg_if;
  logic             valid;
  logic             ready;
  irav_pkg::model_t sensor_model;

  modport source (output valid, output sensor_model, input ready);
  modport sink   (input valid, input sensor_model, output ready);
endinterface

>>> sv/irav_ram.sv
// generic single write port ram with registered read
module irav_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/ir_range_average_linearize.sv
// infrared range averaging and power-law linearization, top level
//
//   port     role    word
//   in_if    sink    channel, sample
//   out_if   source  channel_out, average, distance_mm
//   cfg_if   sink    sensor_model (always ready)
//
// a word reaches out_if.valid after the ring update (S_READ, S_UPD), the bit-serial divide,
// the log2 squarings and the 16 bit-serial square roots of 31 steps each, then the
// product and shift
// in_if.ready is high between words; a word for a channel past the last sensor is dropped
// a finished word waits in the output register while the next word is taken
// rst_n is synchronous and clears ring positions, fill counts, sums and the model
module ir_range_average_linearize (
  input  logic       clk,
  input  logic       rst_n,
  irav_in_if.sink    in_if,
  irav_out_if.source out_if,
  irav_cfg_if.sink   cfg_if
);
  import irav_pkg::*;

  localparam int CH_IW     = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int POS_W     = $clog2(RING_DEPTH);
  localparam int FILL_W    = $clog2(RING_DEPTH + 1);
  localparam int MEM_DEPTH = SENSOR_COUNT * RING_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int DVD_W     = SUM_W + 2;
  localparam int DVS_W     = FILL_W + 1;
  localparam int CNT_W     = $clog2(ROOT_STEPS);
  localparam int RIT_W     = $clog2(FRAC_W);
  localparam int SQ_W      = 2 * X_W;
  localparam int Y_W       = EXP_W + L_W;
  localparam int N_W       = Y_W - 2 * FRAC_W;
  localparam int DP_W      = COEF_W + R_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_UPD,
    S_DIV,
    S_LOGSET,
    S_LOG,
    S_EXP,
    S_RPREP,
    S_ROOT,
    S_MUL,
    S_OUT
  } state_t;

  state_t state_r;
  model_t model_r;

  // per-channel ring bookkeeping
  logic [POS_W-1:0]  wp_r   [SENSOR_COUNT];
  logic [FILL_W-1:0] fill_r [SENSOR_COUNT];
  logic [SUM_W-1:0]  sum_r  [SENSOR_COUNT];

  channel_t ch_r;
  sample_t  sample_r;

  logic [CNT_W-1:0]  cnt_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W-1:0]  div_rem_r;
  logic [MSB_W-1:0]  msb_r;
  logic [X_W-1:0]    x_r;
  logic [FRAC_W-1:0] frac_r;
  logic [N_W-1:0]    n_r;
  logic [FRAC_W-1:0] f_r;
  logic [RIT_W-1:0]  rit_r;
  logic [R_W-1:0]    r_r;
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [R_W-1:0]    root_r;
  logic [DP_W-1:0]   dprod_r;

  logic      out_valid_r;
  channel_t  out_channel_r;
  average_t  out_average_r;
  distance_t out_distance_r;

  logic              ch_ok;
  logic [CH_IW-1:0]  ch_idx;
  logic [POS_W-1:0]  wp_cur;
  logic [FILL_W-1:0] fill_cur;
  logic [SUM_W-1:0]  sum_cur;
  logic              ring_full;
  logic [POS_W-1:0]  wp_new;
  logic [FILL_W-1:0] fill_new;
  logic [SUM_W-1:0]  sum_new;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  sample_t           old_sample;

  logic [DVS_W:0]    div_rem_t;
  logic              div_ge;
  average_t          avg;
  average_t          avg_min;
  average_t          a_clamp;
  logic [MSB_W-1:0]  lead_pos;
  logic [SQ_W-1:0]   sq_full;
  logic [X_W:0]      sq_top;
  logic [EXP_W-1:0]  exp_q16;
  logic [Y_W-1:0]    y_full;
  logic [R_W-1:0]    r_half;
  logic [REM_W+1:0]  rt_rem_t;
  logic [REM_W+1:0]  rt_trial;
  logic              rt_ge;
  logic [COEF_W-1:0] coef;
  logic [DP_W-1:0]   dshift;
  distance_t         dist_sat;
  logic              out_load;

  // ring slot of the current word
  assign ch_ok     = int'(in_if.channel) < SENSOR_COUNT;
  assign ch_idx    = CH_IW'(ch_r);
  assign wp_cur    = wp_r[ch_idx];
  assign fill_cur  = fill_r[ch_idx];
  assign sum_cur   = sum_r[ch_idx];
  assign ring_full = (fill_cur == FILL_W'(RING_DEPTH));
  assign wp_new    = (wp_cur == POS_W'(RING_DEPTH - 1)) ? '0 : wp_cur + 1'b1;
  assign fill_new  = ring_full ? fill_cur : fill_cur + 1'b1;
  assign sum_new   = (ring_full ? sum_cur - SUM_W'(old_sample) : sum_cur) + SUM_W'(sample_r);
  assign mem_addr  = ADDR_W'(int'(ch_idx) * RING_DEPTH) + ADDR_W'(wp_cur);
  assign mem_we    = (state_r == S_UPD);

  irav_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (sample_r),
    .raddr (mem_addr),
    .rdata (old_sample)
  );

  // restoring divide, one quotient bit a cycle
  assign div_rem_t = {div_rem_r, dvd_r[DVD_W-1]};
  assign div_ge    = (div_rem_t >= {1'b0, dvs_r});

  // clamp and leading one of the mean
  assign avg     = dvd_r[AVERAGE_W-1:0];
  assign avg_min = (model_r == MODEL_MEDIUM) ? AVERAGE_W'(MIN_MEDIUM) : AVERAGE_W'(MIN_SHORT);
  assign a_clamp = (avg < avg_min) ? avg_min : avg;

  always_comb begin
    lead_pos = '0;
    for (int i = 0; i < AVERAGE_W; i++) begin
      if (a_clamp[i]) begin
        lead_pos = MSB_W'(i);
      end
    end
  end

  // log2 fraction: square the mantissa, renormalize when it reaches two
  assign sq_full = x_r * x_r;
  assign sq_top  = sq_full[SQ_W-1:X_W-1];

  assign exp_q16 = (model_r == MODEL_MEDIUM) ? EXP_W'(EXP_MEDIUM_Q16) : EXP_W'(EXP_SHORT_Q16);
  assign y_full  = exp_q16 * {msb_r, frac_r};

  // 2^-f: per fraction bit an optional halving, then a square root of r in q30
  assign r_half   = f_r[0] ? (r_r >> 1) : r_r;
  assign rt_rem_t = {rem_r, rad_r[RAD_W-1:RAD_W-2]};
  assign rt_trial = (REM_W + 2)'({root_r, 2'b01});
  assign rt_ge    = (rt_rem_t >= rt_trial);

  assign coef     = (model_r == MODEL_MEDIUM) ? COEF_W'(COEF_MEDIUM) : COEF_W'(COEF_SHORT);
  assign dshift   = dprod_r >> (int'(n_r) + (R_W - 1));
  assign dist_sat = (|dshift[DP_W-1:DISTANCE_W]) ? '1 : dshift[DISTANCE_W-1:0];

  // finished word moves into the output register once it is free
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_if.ready);

  assign in_if.ready        = (state_r == S_IDLE);
  assign cfg_if.ready       = 1'b1;
  assign out_if.valid       = out_valid_r;
  assign out_if.channel_out = out_channel_r;
  assign out_if.average     = out_average_r;
  assign out_if.distance_mm = out_distance_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      model_r     <= MODEL_SHORT;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        wp_r[i]   <= '0;
        fill_r[i] <= '0;
        sum_r[i]  <= '0;
      end
    end else begin
      if (cfg_if.valid) begin
        model_r <= cfg_if.sensor_model;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid && ch_ok) begin
            ch_r     <= in_if.channel;
            sample_r <= in_if.sample;
            state_r  <= S_READ;
          end
        end
        S_READ: begin
          // old slot value arrives from the ram next cycle
          state_r <= S_UPD;
        end
        S_UPD: begin
          wp_r[ch_idx]   <= wp_new;
          fill_r[ch_idx] <= fill_new;
          sum_r[ch_idx]  <= sum_new;
          // round half up: (2*sum + n) / (2*n)
          dvd_r          <= DVD_W'({sum_new, 1'b0}) + DVD_W'(fill_new);
          dvs_r          <= {fill_new, 1'b0};
          div_rem_r      <= '0;
          cnt_r          <= '0;
          state_r        <= S_DIV;
        end
        S_DIV: begin
          dvd_r     <= {dvd_r[DVD_W-2:0], div_ge};
          div_rem_r <= DVS_W'(div_ge ? div_rem_t - {1'b0, dvs_r} : div_rem_t);
          if (cnt_r == CNT_W'(DVD_W - 1)) begin
            state_r <= S_LOGSET;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_LOGSET: begin
          msb_r   <= lead_pos;
          x_r     <= X_W'(a_clamp) << ((X_W - 1) - int'(lead_pos));
          frac_r  <= '0;
          cnt_r   <= '0;
          state_r <= S_LOG;
        end
        S_LOG: begin
          x_r    <= sq_top[X_W] ? sq_top[X_W:1] : sq_top[X_W-1:0];
          frac_r <= {frac_r[FRAC_W-2:0], sq_top[X_W]};
          if (cnt_r == CNT_W'(FRAC_W - 1)) begin
            state_r <= S_EXP;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_EXP: begin
          n_r     <= y_full[Y_W-1:2*FRAC_W];
          f_r     <= y_full[2*FRAC_W-1:FRAC_W];
          r_r     <= {1'b1, (R_W - 1)'(0)};
          rit_r   <= '0;
          state_r <= S_RPREP;
        end
        S_RPREP: begin
          rad_r   <= {1'b0, r_half, (RAD_W - R_W - 1)'(0)};
          rem_r   <= '0;
          root_r  <= '0;
          cnt_r   <= '0;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          rad_r  <= rad_r << 2;
          rem_r  <= REM_W'(rt_ge ? rt_rem_t - rt_trial : rt_rem_t);
          root_r <= {root_r[R_W-2:0], rt_ge};
          if (cnt_r == CNT_W'(ROOT_STEPS - 1)) begin
            r_r <= {root_r[R_W-2:0], rt_ge};
            f_r <= f_r >> 1;
            if (rit_r == RIT_W'(FRAC_W - 1)) begin
              state_r <= S_MUL;
            end else begin
              rit_r   <= rit_r + 1'b1;
              state_r <= S_RPREP;
            end
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_MUL: begin
          dprod_r <= coef * r_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_channel_r  <= ch_r;
            out_average_r  <= avg;
            out_distance_r <= dist_sat;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
